### rtl/core/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and constants for the byte-level I2C master timing engine.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    // Field widths.
    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int TMO_W   = 10;
    localparam int DLY_W   = 18;
    localparam int BITC_W  = 4;
    localparam int CFG_W   = 16;

    // Queue between the front and the back.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    localparam logic CFG_UNIT_TICKS  = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    // Raw command codes on the input channel.
    localparam logic [CMD_W-1:0] CMD_NONE      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WAIT_ACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_ACK  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ_NACK = 3'd6;

    // Bus timing, in delay units, as shifts of the unit length.
    localparam int START_SHIFT = 2;   // four units
    localparam int BIT_SHIFT   = 1;   // two units
    localparam logic [BITC_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_START,
        KIND_STOP,
        KIND_WRITE,
        KIND_WAIT_ACK,
        KIND_READ_ACK,
        KIND_READ_NACK
    } cmd_kind_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_B,
        PH_START_C,
        PH_STOP_B,
        PH_STOP_C,
        PH_WR_A,
        PH_WR_B,
        PH_WR_C,
        PH_WA_B,
        PH_WA_POLL,
        PH_RD_B,
        PH_RD_C,
        PH_RA_B,
        PH_RA_C
    } phase_t;

    // One classified item in the queue.
    typedef struct packed {
        cmd_kind_t           kind;
        logic [BYTE_W-1:0]   tx_byte;
        logic                sda_in;
    } q_entry_t;

    typedef struct packed {
        logic [UNIT_W-1:0] unit_ticks;
        logic [TMO_W-1:0]  ack_timeout;
    } cfg_t;

    // Queue status seen by the front.
    typedef struct packed {
        logic              full;
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

### rtl/core/i2cbm_front.sv
// ----------------------------------------------------------------------------
// i2cbm_front
// Input handshake and command classification ahead of the item queue.
// ----------------------------------------------------------------------------
module i2cbm_front (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [i2cbm_pkg::CMD_W-1:0]   s_cmd,
    input  logic [i2cbm_pkg::BYTE_W-1:0]  s_tx_byte,
    input  logic                          s_sda_in,
    input  i2cbm_pkg::q_status_t          q_status,
    output logic                          push,
    output i2cbm_pkg::q_entry_t           push_entry
);

    i2cbm_pkg::cmd_kind_t kind;

    always_comb begin
        unique case (s_cmd)
            i2cbm_pkg::CMD_START:     kind = i2cbm_pkg::KIND_START;
            i2cbm_pkg::CMD_STOP:      kind = i2cbm_pkg::KIND_STOP;
            i2cbm_pkg::CMD_WRITE:     kind = i2cbm_pkg::KIND_WRITE;
            i2cbm_pkg::CMD_WAIT_ACK:  kind = i2cbm_pkg::KIND_WAIT_ACK;
            i2cbm_pkg::CMD_READ_ACK:  kind = i2cbm_pkg::KIND_READ_ACK;
            i2cbm_pkg::CMD_READ_NACK: kind = i2cbm_pkg::KIND_READ_NACK;
            default:                  kind = i2cbm_pkg::KIND_NONE;
        endcase
    end

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    assign push_entry.kind    = kind;
    assign push_entry.tx_byte = s_tx_byte;
    assign push_entry.sda_in  = s_sda_in;

endmodule

### rtl/core/i2cbm_queue.sv
// ----------------------------------------------------------------------------
// i2cbm_queue
// Short register queue that decouples the front from the timing engine.
// ----------------------------------------------------------------------------
module i2cbm_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  i2cbm_pkg::q_entry_t   push_entry,
    input  logic                  pop,
    output logic                  q_valid,
    output i2cbm_pkg::q_entry_t   q_head,
    output i2cbm_pkg::q_status_t  q_status
);

    i2cbm_pkg::q_entry_t entry_reg [i2cbm_pkg::QDEPTH];

    logic [i2cbm_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [i2cbm_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [i2cbm_pkg::QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == i2cbm_pkg::QPTR_W'(i2cbm_pkg::QDEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == i2cbm_pkg::QPTR_W'(i2cbm_pkg::QDEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign q_valid        = (count_reg != '0);
    assign q_head         = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == i2cbm_pkg::QCNT_W'(i2cbm_pkg::QDEPTH));
    assign q_status.count = count_reg;

endmodule

### rtl/core/i2cbm_engine.sv
// ----------------------------------------------------------------------------
// i2cbm_engine
// Bus timing engine: runs one item per cycle unless stalled, registers the result.
// ----------------------------------------------------------------------------
module i2cbm_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  i2cbm_pkg::cfg_t               cfg,
    input  logic                          q_valid,
    input  i2cbm_pkg::q_entry_t           q_head,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_scl,
    output logic                          m_sda_out,
    output logic                          m_sda_drive,
    output logic                          m_busy_res,
    output logic                          m_done_res,
    output logic [i2cbm_pkg::BYTE_W-1:0]  m_rx_byte,
    output logic                          m_ack_fail
);

    i2cbm_pkg::phase_t    phase_reg, phase_next;
    i2cbm_pkg::cmd_kind_t active_reg, active_next;

    logic [i2cbm_pkg::BITC_W-1:0] bit_count_reg, bit_count_next;
    logic [i2cbm_pkg::DLY_W-1:0]  delay_reg, delay_next;
    logic [i2cbm_pkg::TMO_W-1:0]  wait_reg, wait_next;
    logic [i2cbm_pkg::BYTE_W-1:0] shift_reg, shift_next;
    logic scl_reg, scl_next;
    logic sda_reg, sda_next;
    logic en_reg, en_next;
    logic fail_reg, fail_next;
    logic done;

    logic [i2cbm_pkg::DLY_W-1:0]  dly_one, dly_bit, dly_start, delay_dec;
    logic [i2cbm_pkg::UNIT_W-1:0] unit_eff;
    logic [i2cbm_pkg::BITC_W-1:0] bit_inc;

    // Output register.
    logic                         m_valid_reg;
    logic                         scl_out_reg, sda_out_reg, drive_out_reg;
    logic                         busy_out_reg, done_out_reg, fail_out_reg;
    logic [i2cbm_pkg::BYTE_W-1:0] rx_out_reg;
    logic [i2cbm_pkg::BYTE_W-1:0] rx_next;

    // A zero unit length counts as one tick per unit.
    assign unit_eff  = (cfg.unit_ticks == '0) ? i2cbm_pkg::UNIT_W'(1) : cfg.unit_ticks;
    assign dly_one   = i2cbm_pkg::DLY_W'(unit_eff);
    assign dly_bit   = dly_one << i2cbm_pkg::BIT_SHIFT;
    assign dly_start = dly_one << i2cbm_pkg::START_SHIFT;
    assign delay_dec = delay_reg - 1'b1;
    assign bit_inc   = bit_count_reg + 1'b1;

    // The engine advances whenever the output register can take a result.
    assign pop = q_valid && (!m_valid_reg || m_ready);

    always_comb begin
        phase_next     = phase_reg;
        active_next    = active_reg;
        bit_count_next = bit_count_reg;
        delay_next     = delay_reg;
        wait_next      = wait_reg;
        shift_next     = shift_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        en_next        = en_reg;
        fail_next      = fail_reg;
        done           = 1'b0;

        if (phase_reg == i2cbm_pkg::PH_IDLE) begin
            if (q_head.kind != i2cbm_pkg::KIND_NONE) begin
                active_next = q_head.kind;
                case (q_head.kind)
                    i2cbm_pkg::KIND_START: begin
                        en_next    = 1'b1;
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        delay_next = dly_start;
                        phase_next = i2cbm_pkg::PH_START_B;
                    end
                    i2cbm_pkg::KIND_STOP: begin
                        en_next    = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        delay_next = dly_start;
                        phase_next = i2cbm_pkg::PH_STOP_B;
                    end
                    i2cbm_pkg::KIND_WRITE: begin
                        en_next        = 1'b1;
                        scl_next       = 1'b0;
                        shift_next     = q_head.tx_byte;
                        bit_count_next = '0;
                        delay_next     = dly_bit;
                        phase_next     = i2cbm_pkg::PH_WR_A;
                    end
                    i2cbm_pkg::KIND_WAIT_ACK: begin
                        fail_next  = 1'b0;
                        en_next    = 1'b0;
                        sda_next   = 1'b1;
                        delay_next = dly_one;
                        phase_next = i2cbm_pkg::PH_WA_B;
                    end
                    default: begin
                        en_next        = 1'b0;
                        scl_next       = 1'b0;
                        shift_next     = '0;
                        bit_count_next = '0;
                        delay_next     = dly_bit;
                        phase_next     = i2cbm_pkg::PH_RD_B;
                    end
                endcase
            end
        end else if (delay_reg == '0 || delay_dec == '0) begin
            // The pending step runs on the tick its delay runs out.
            delay_next = '0;
            unique case (phase_reg)
                i2cbm_pkg::PH_START_B: begin
                    sda_next   = 1'b0;
                    delay_next = dly_start;
                    phase_next = i2cbm_pkg::PH_START_C;
                end
                i2cbm_pkg::PH_START_C: begin
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
                i2cbm_pkg::PH_STOP_B: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    delay_next = dly_start;
                    phase_next = i2cbm_pkg::PH_STOP_C;
                end
                i2cbm_pkg::PH_STOP_C: begin
                    done = 1'b1;
                end
                i2cbm_pkg::PH_WR_A: begin
                    sda_next   = shift_reg[i2cbm_pkg::BYTE_W-1];
                    delay_next = dly_bit;
                    phase_next = i2cbm_pkg::PH_WR_B;
                end
                i2cbm_pkg::PH_WR_B: begin
                    scl_next   = 1'b1;
                    delay_next = dly_bit;
                    phase_next = i2cbm_pkg::PH_WR_C;
                end
                i2cbm_pkg::PH_WR_C: begin
                    scl_next       = 1'b0;
                    shift_next     = {shift_reg[i2cbm_pkg::BYTE_W-2:0], 1'b0};
                    bit_count_next = bit_inc;
                    if (bit_inc >= i2cbm_pkg::BITS_PER_BYTE) begin
                        done = 1'b1;
                    end else begin
                        delay_next = dly_bit;
                        phase_next = i2cbm_pkg::PH_WR_A;
                    end
                end
                i2cbm_pkg::PH_WA_B: begin
                    scl_next   = 1'b1;
                    wait_next  = '0;
                    delay_next = dly_one;
                    phase_next = i2cbm_pkg::PH_WA_POLL;
                end
                i2cbm_pkg::PH_WA_POLL: begin
                    if (!q_head.sda_in) begin
                        scl_next  = 1'b0;
                        fail_next = 1'b0;
                        done      = 1'b1;
                    end else if (wait_reg >= cfg.ack_timeout) begin
                        // Timeout: flag the failure and release the bus with a stop.
                        fail_next  = 1'b1;
                        en_next    = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        delay_next = dly_start;
                        phase_next = i2cbm_pkg::PH_STOP_B;
                    end else begin
                        wait_next = wait_reg + 1'b1;
                    end
                end
                i2cbm_pkg::PH_RD_B: begin
                    scl_next       = 1'b1;
                    shift_next     = {shift_reg[i2cbm_pkg::BYTE_W-2:0], q_head.sda_in};
                    bit_count_next = bit_inc;
                    delay_next     = dly_one;
                    phase_next     = i2cbm_pkg::PH_RD_C;
                end
                i2cbm_pkg::PH_RD_C: begin
                    scl_next   = 1'b0;
                    delay_next = dly_bit;
                    if (bit_count_reg < i2cbm_pkg::BITS_PER_BYTE) begin
                        phase_next = i2cbm_pkg::PH_RD_B;
                    end else begin
                        en_next    = 1'b1;
                        sda_next   = (active_reg == i2cbm_pkg::KIND_READ_NACK);
                        phase_next = i2cbm_pkg::PH_RA_B;
                    end
                end
                i2cbm_pkg::PH_RA_B: begin
                    scl_next   = 1'b1;
                    delay_next = dly_bit;
                    phase_next = i2cbm_pkg::PH_RA_C;
                end
                i2cbm_pkg::PH_RA_C: begin
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
                default: begin
                    done = 1'b1;
                end
            endcase
            if (done) begin
                phase_next = i2cbm_pkg::PH_IDLE;
                delay_next = '0;
            end
        end else begin
            delay_next = delay_dec;
        end

        if (done && (active_next == i2cbm_pkg::KIND_READ_ACK ||
                     active_next == i2cbm_pkg::KIND_READ_NACK)) begin
            rx_next = shift_next;
        end else begin
            rx_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= i2cbm_pkg::PH_IDLE;
            active_reg    <= i2cbm_pkg::KIND_NONE;
            bit_count_reg <= '0;
            delay_reg     <= '0;
            wait_reg      <= '0;
            shift_reg     <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            en_reg        <= 1'b1;
            fail_reg      <= 1'b0;
        end else if (pop) begin
            phase_reg     <= phase_next;
            active_reg    <= active_next;
            bit_count_reg <= bit_count_next;
            delay_reg     <= delay_next;
            wait_reg      <= wait_next;
            shift_reg     <= shift_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            en_reg        <= en_next;
            fail_reg      <= fail_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            scl_out_reg   <= scl_next;
            sda_out_reg   <= sda_next;
            drive_out_reg <= en_next;
            busy_out_reg  <= (phase_next != i2cbm_pkg::PH_IDLE);
            done_out_reg  <= done;
            rx_out_reg    <= rx_next;
            fail_out_reg  <= fail_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_scl       = scl_out_reg;
    assign m_sda_out   = sda_out_reg;
    assign m_sda_drive = drive_out_reg;
    assign m_busy_res  = busy_out_reg;
    assign m_done_res  = done_out_reg;
    assign m_rx_byte   = rx_out_reg;
    assign m_ack_fail  = fail_out_reg;

endmodule

### rtl/core/i2c_bit_level_master_core.sv
// ----------------------------------------------------------------------------
// i2c_bit_level_master_core
// Byte-level I2C master: one input item per bus timing tick, one result each.
// ----------------------------------------------------------------------------
// Path: an accepted item is registered in the item queue, then in the engine's
// output register. Throughput: one item per cycle while results are taken; the
// timing engine updates once per item. Reset: synchronous, active low; the
// engine's SCL and SDA state goes high but its output register is not reset;
// the queue empties and the configuration returns to 72 ticks and 250 ticks.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [i2cbm_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [i2cbm_pkg::CMD_W-1:0]    s_cmd,
    input  logic [i2cbm_pkg::BYTE_W-1:0]   s_tx_byte,
    input  logic                           s_sda_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_scl,
    output logic                           m_sda_out,
    output logic                           m_sda_drive,
    output logic                           m_busy_res,
    output logic                           m_done_res,
    output logic [i2cbm_pkg::BYTE_W-1:0]   m_rx_byte,
    output logic                           m_ack_fail
);

    i2cbm_pkg::cfg_t      cfg_reg;
    i2cbm_pkg::q_status_t q_status;
    i2cbm_pkg::q_entry_t  push_entry;
    i2cbm_pkg::q_entry_t  q_head;
    logic                 push;
    logic                 pop;
    logic                 q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.unit_ticks  <= i2cbm_pkg::UNIT_W'(72);
            cfg_reg.ack_timeout <= i2cbm_pkg::TMO_W'(250);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                i2cbm_pkg::CFG_UNIT_TICKS:
                    cfg_reg.unit_ticks  <= cfg_wdata[i2cbm_pkg::UNIT_W-1:0];
                i2cbm_pkg::CFG_ACK_TIMEOUT:
                    cfg_reg.ack_timeout <= cfg_wdata[i2cbm_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    i2cbm_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_tx_byte  (s_tx_byte),
        .s_sda_in   (s_sda_in),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    i2cbm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_status   (q_status)
    );

    i2cbm_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl       (m_scl),
        .m_sda_out   (m_sda_out),
        .m_sda_drive (m_sda_drive),
        .m_busy_res  (m_busy_res),
        .m_done_res  (m_done_res),
        .m_rx_byte   (m_rx_byte),
        .m_ack_fail  (m_ack_fail)
    );

    // A finished command always leaves the engine idle.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> !m_busy_res)
        else $error("done result reports busy");

    // A received byte is only reported together with the done pulse.
    a_rx_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_rx_byte != '0)) |-> m_done_res)
        else $error("rx byte outside a done result");

    // The engine never draws from an empty queue.
    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (q_status.count != '0))
        else $error("engine advanced without a queued item");

    // Nothing is offered on the result side right after reset.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule
